>>> src/generational_handle_pool_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the generational handle pool core
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_POOL_CORE_MACROS_SVH
`define GENERATIONAL_HANDLE_POOL_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante
`ifndef SYNTHESIS
`define GHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("handle pool check failed");
`else
`define GHP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif

// Check that cons holds in the cycle after ante
`ifndef SYNTHESIS
`define GHP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("handle pool check failed");
`else
`define GHP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/ghp_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle pool package
// Item types, operation and status codes, parameter defaults.
// ----------------------------------------------------------------------------
package ghp_pkg;

	// parameter defaults
	localparam int CAPACITY_DEF     = 256;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int GEN_BITS_DEF     = 16;

	// operation codes
	localparam logic [2:0] OP_CREATE  = 3'd0;
	localparam logic [2:0] OP_DESTROY = 3'd1;
	localparam logic [2:0] OP_GET     = 3'd2;
	localparam logic [2:0] OP_FIND    = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_INVALID   = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	// command item
	typedef struct packed {
		logic [2:0]  op;
		logic        handle_empty;
		logic [7:0]  handle_slot;
		logic [15:0] handle_gen;
		logic [31:0] payload_in;
		logic        payload_given;
	} cmd_t;

	// result item
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  out_slot;
		logic [15:0] out_gen;
		logic [31:0] payload_out;
		logic [8:0]  live_objects;
	} rsp_t;

endpackage

>>> src/ghp_slot_ram.sv
// ----------------------------------------------------------------------------
// Slot memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ghp_slot_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 57
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> src/generational_handle_pool_core.sv
// ----------------------------------------------------------------------------
// Generational handle pool core
// Slot pool handing out slot-plus-generation handles, kept in one slot RAM.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. For create, destroy,
// get and clear, the accepting edge reads the addressed slot from the RAM, and
// the next cycle checks, modifies and writes back the entry and registers the
// result. Find reads one slot per cycle from slot 0 upwards and examines N
// slots (at least one, at most the larger of one and the high-water mark),
// since the RAM delivers one entry a cycle. Each result appears on rsp for
// exactly one cycle with done high; the receiver cannot stall it, so it must
// be captured then. busy stays high until the cycle in which the result is
// shown, when a new command may already be taken.
// No clearing pass is needed after reset; unused slots are never read back.
// ----------------------------------------------------------------------------
`include "generational_handle_pool_core_macros.svh"

module generational_handle_pool_core
	import ghp_pkg::*;
#(
	parameter int CAPACITY     = CAPACITY_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
	parameter int GEN_BITS     = GEN_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam int SW = $clog2(CAPACITY);        // slot index
	localparam int CW = $clog2(CAPACITY + 1);    // counts and list links
	localparam int XW = (CW > 8) ? CW : 8;       // handle slot compare
	localparam int GW = (GEN_BITS > 16) ? GEN_BITS : 16;
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	typedef struct packed {
		logic [PAYLOAD_BITS-1:0] payload;
		logic [GEN_BITS-1:0]     gen;
		logic [CW-1:0]           link;
	} entry_t;

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t        state_q;
	cmd_t          cmd_q;
	rsp_t          rsp_q;
	logic          done_q;
	logic [CW-1:0] free_head_q;
	logic [CW-1:0] hw_q;
	logic [CW-1:0] live_q;
	logic [CW-1:0] scan_q;

	entry_t        rd_entry;
	entry_t        wr_entry;
	logic          wr_en;
	logic [SW-1:0] wr_addr;
	logic [SW-1:0] rd_addr;
	logic [SW-1:0] idle_addr;

	logic          fin;
	rsp_t          rsp_n;
	logic [CW-1:0] free_head_n;
	logic [CW-1:0] hw_n;
	logic [CW-1:0] live_n;
	logic [CW-1:0] scan_inc;
	logic [PAYLOAD_BITS-1:0] pin;
	logic          handle_ok;
	logic          accept;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign rsp      = rsp_q;
	assign scan_inc = scan_q + 1'b1;
	assign pin      = PAYLOAD_BITS'(cmd_q.payload_in);

	// pick the slot to fetch for a new command
	always_comb begin
		case (cmd.op)
			OP_CREATE:          idle_addr = SW'(free_head_q);
			OP_DESTROY, OP_GET: idle_addr = SW'(cmd.handle_slot);
			default:            idle_addr = '0;
		endcase
	end

	// during a find, fetch the slot after the one being compared
	assign rd_addr = (state_q == S_IDLE) ? idle_addr : SW'(scan_inc);

	ghp_slot_ram #(
		.DEPTH (CAPACITY),
		.WIDTH ($bits(entry_t))
	) u_slot_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_entry),
		.raddr (rd_addr),
		.rdata (rd_entry)
	);

	// handle names a slot below the high-water mark with a matching generation
	assign handle_ok = (XW'(cmd_q.handle_slot) < XW'(hw_q)) &&
	                   (GW'(rd_entry.gen) == GW'(cmd_q.handle_gen));

	// execute the held command against the fetched entry
	always_comb begin
		fin         = 1'b1;
		wr_en       = 1'b0;
		wr_addr     = SW'(cmd_q.handle_slot);
		wr_entry    = rd_entry;
		free_head_n = free_head_q;
		hw_n        = hw_q;
		live_n      = live_q;
		rsp_n       = '0;
		rsp_n.status = ST_OK;
		case (cmd_q.op)
			OP_CREATE: begin
				if (live_q >= CAP) begin
					rsp_n.status = ST_FULL;
				end else if (free_head_q < CAP) begin
					// pop the free-list head, keep its generation
					wr_en            = 1'b1;
					wr_addr          = SW'(free_head_q);
					wr_entry.payload = pin;
					free_head_n      = rd_entry.link;
					live_n           = live_q + 1'b1;
					rsp_n.out_slot   = 8'(free_head_q);
					rsp_n.out_gen    = 16'(rd_entry.gen);
				end else if (hw_q < CAP) begin
					// append a fresh slot at generation zero
					wr_en            = 1'b1;
					wr_addr          = SW'(hw_q);
					wr_entry.payload = pin;
					wr_entry.gen     = '0;
					hw_n             = hw_q + 1'b1;
					live_n           = live_q + 1'b1;
					rsp_n.out_slot   = 8'(hw_q);
				end else begin
					rsp_n.status = ST_FULL;
				end
			end
			OP_DESTROY: begin
				if (cmd_q.handle_empty) begin
					rsp_n.status = ST_EMPTY;
				end else if ((live_q == '0) || !handle_ok) begin
					rsp_n.status = ST_INVALID;
				end else begin
					// zero, bump generation, push onto the free list
					wr_en            = 1'b1;
					wr_entry.payload = '0;
					wr_entry.gen     = GEN_BITS'(rd_entry.gen + 1'b1);
					wr_entry.link    = free_head_q;
					free_head_n      = CW'(cmd_q.handle_slot);
					live_n           = live_q - 1'b1;
				end
			end
			OP_GET: begin
				if (cmd_q.handle_empty) begin
					rsp_n.status = ST_EMPTY;
				end else if (!handle_ok) begin
					rsp_n.status = ST_INVALID;
				end else begin
					rsp_n.out_slot    = cmd_q.handle_slot;
					rsp_n.out_gen     = cmd_q.handle_gen;
					rsp_n.payload_out = 32'(rd_entry.payload);
				end
			end
			OP_FIND: begin
				if (!cmd_q.payload_given) begin
					rsp_n.status = ST_EMPTY;
				end else if ((scan_q < hw_q) && (rd_entry.payload == pin)) begin
					rsp_n.out_slot = 8'(scan_q);
					rsp_n.out_gen  = 16'(rd_entry.gen);
				end else if (scan_inc < hw_q) begin
					// advance to the next slot
					fin = 1'b0;
				end else begin
					rsp_n.status = ST_NOT_FOUND;
				end
			end
			OP_CLEAR: begin
				free_head_n = CAP;
				hw_n        = '0;
				live_n      = '0;
			end
			default: begin
				rsp_n.status = ST_INVALID;
			end
		endcase
		rsp_n.live_objects = 9'(live_n);
		if (state_q != S_EXEC) begin
			wr_en = 1'b0;
		end
	end

	// sequencer, pool counters and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			rsp_q       <= '0;
			done_q      <= 1'b0;
			free_head_q <= CAP;
			hw_q        <= '0;
			live_q      <= '0;
			scan_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= cmd;
						scan_q  <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fin) begin
						rsp_q       <= rsp_n;
						done_q      <= 1'b1;
						free_head_q <= free_head_n;
						hw_q        <= hw_n;
						live_q      <= live_n;
						state_q     <= S_IDLE;
					end else begin
						scan_q <= scan_inc;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result shown only once the sequencer has returned to idle
	`GHP_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, !busy)
	// accepted command always occupies the sequencer next cycle
	`GHP_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, busy)
	// live count never exceeds the pool size
	`GHP_ASSERT_IMP(a_live_cap, clk, arst_n, 1'b1, live_q <= CAP)
	// a non-empty free list always points below the high-water mark
	`GHP_ASSERT_IMP(a_head_hw, clk, arst_n, free_head_q != CAP, free_head_q < hw_q)

endmodule
